FILE: rtl/aes_counter_passcode_generator_defines.svh
// Assertion macros for the passcode generator.
// Included by the top level; no other dependencies.
`ifndef AES_COUNTER_PASSCODE_GENERATOR_DEFINES_SVH
`define AES_COUNTER_PASSCODE_GENERATOR_DEFINES_SVH
// Check that an antecedent implies a consequent on the next edge.
`define ACPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Check that an antecedent implies a consequent on the same edge.
`define ACPG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/acpg_pkg.sv
// Shared types, constants and AES helpers for the passcode generator.
// No dependencies.
package acpg_pkg;
   localparam int MAX_CODE_LENGTH = 16;
   localparam int CODE_LENGTH_MIN = 2;
   localparam int AES_ROUNDS = 14;
   localparam int LEN_W = 5;
   localparam int IDX_W = 4;
   localparam int CNT_W = $clog2(MAX_CODE_LENGTH + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int ROUND_W = 4;

   localparam logic [2:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [2:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [2:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [2:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [2:0] CSR_CODE_LENGTH = 3'd4;

   typedef struct packed {
      logic [127:0] block;
      logic [CNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic [127:0] text;
      logic [CNT_W-1:0] count;
   } cipher_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a 128-bit block is bits 127-8i down to 120-8i.
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0] sb [16];
      logic [7:0] sh [16];
      logic [7:0] a0, a1, a2, a3, all;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) sb[i] = sbox(s[127-8*i -: 8]);
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 4; i++) sh[i+4*c] = sb[i + 4*((c+i) & 3)];
      for (int c = 0; c < 4; c++) begin
         a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
         all = a0 ^ a1 ^ a2 ^ a3;
         if (!last) begin
            sh[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
            sh[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
            sh[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
            sh[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = sh[i];
      return o ^ rk;
   endfunction

   // Next 128 bits of AES-256 key schedule from the previous 256 bits.
   // odd selects the SubWord-only half step.
   function automatic logic [127:0] key_step(input logic [255:0] w, input logic odd,
                                             input logic [7:0] rcon);
      logic [31:0] t, p;
      logic [127:0] o;
      t = w[31:0];
      if (odd) t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
      else t = {sbox(t[23:16]) ^ rcon, sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])};
      p = w[255:224] ^ t; o[127:96] = p;
      p = w[223:192] ^ p; o[95:64] = p;
      p = w[191:160] ^ p; o[63:32] = p;
      p = w[159:128] ^ p; o[31:0] = p;
      return o;
   endfunction

   function automatic logic [6:0] glyph(input logic [5:0] d);
      logic [6:0] g [64];
      g = '{7'h21,7'h23,7'h25,7'h2b,7'h32,7'h33,7'h34,7'h35,7'h36,7'h37,7'h38,7'h39,
            7'h3a,7'h3d,7'h3f,7'h40,
            7'h41,7'h42,7'h43,7'h44,7'h45,7'h46,7'h47,7'h48,7'h4a,7'h4b,7'h4c,7'h4d,
            7'h4e,7'h50,7'h52,7'h53,7'h54,7'h55,7'h56,7'h57,7'h58,7'h59,7'h5a,
            7'h61,7'h62,7'h63,7'h64,7'h65,7'h66,7'h67,7'h68,7'h69,7'h6a,7'h6b,7'h6d,
            7'h6e,7'h6f,7'h70,7'h71,7'h72,7'h73,7'h74,7'h75,7'h76,7'h77,7'h78,7'h79,7'h7a};
      return g[d];
   endfunction
endpackage

FILE: rtl/aes_counter_passcode_generator.sv
// Passcode generator: AES-256 of a counter, emitted as base-64 characters.
// A request passes through the front queue, the cipher with its 14 AES rounds,
// and the serializer and its output register. The cipher can work on the next
// counter while the serializer emits the previous one at one character per
// cycle when the output is not stalled.
// Reset (synchronous): queues empty, key zero, code_length 4.
`include "aes_counter_passcode_generator_defines.svh"
module aes_counter_passcode_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_counter_low,
   input  logic [63:0] req_counter_high,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_char_code,
   output logic [3:0]  rsp_char_index,
   output logic        rsp_last_char,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [63:0] key_ff [4];
   logic [acpg_pkg::LEN_W-1:0] len_ff;
   logic job_valid, job_take, ct_valid, ct_take;
   acpg_pkg::job_type job;
   acpg_pkg::cipher_type ct;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '{default: '0};
         len_ff <= acpg_pkg::LEN_W'(4);
      end else if (csr_write) begin
         case (csr_index)
            acpg_pkg::CSR_KEY_WORD_0: key_ff[0] <= csr_data;
            acpg_pkg::CSR_KEY_WORD_1: key_ff[1] <= csr_data;
            acpg_pkg::CSR_KEY_WORD_2: key_ff[2] <= csr_data;
            acpg_pkg::CSR_KEY_WORD_3: key_ff[3] <= csr_data;
            acpg_pkg::CSR_CODE_LENGTH: len_ff <= csr_data[acpg_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   acpg_front u_front (
      .clock, .reset, .req_push, .req_full, .req_counter_low, .req_counter_high,
      .code_length(len_ff), .job_valid, .job_take, .job
   );

   acpg_cipher u_cipher (
      .clock, .reset, .key({key_ff[3], key_ff[2], key_ff[1], key_ff[0]}),
      .job_valid, .job_take, .job, .ct_valid, .ct_take, .ct
   );

   acpg_serializer u_ser (
      .clock, .reset, .ct_valid, .ct_take, .ct, .rsp_empty, .rsp_pop,
      .rsp_char_code, .rsp_char_index, .rsp_last_char
   );

   `ACPG_ASSERT_NEXT(a_hold_out, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_char_code))
   `ACPG_ASSERT_NOW(a_last_len, clock, reset, !rsp_empty && rsp_char_index == 4'd0, !rsp_last_char)
   `ACPG_ASSERT_NOW(a_take_valid, clock, reset, job_take, job_valid)
endmodule

FILE: rtl/acpg_front.sv
// Front end: accepts counter requests, clamps the length, and queues jobs.
// Depends on acpg_pkg.
module acpg_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [63:0]               req_counter_low,
   input  logic [63:0]               req_counter_high,
   input  logic [acpg_pkg::LEN_W-1:0] code_length,
   output logic                      job_valid,
   input  logic                      job_take,
   output acpg_pkg::job_type         job
);
   acpg_pkg::job_type q_ff [acpg_pkg::QUEUE_DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic push, take;
   logic [acpg_pkg::CNT_W-1:0] n;

   always_comb begin
      if (code_length < acpg_pkg::LEN_W'(acpg_pkg::CODE_LENGTH_MIN))
         n = acpg_pkg::CNT_W'(acpg_pkg::CODE_LENGTH_MIN);
      else if (code_length > acpg_pkg::LEN_W'(acpg_pkg::MAX_CODE_LENGTH))
         n = acpg_pkg::CNT_W'(acpg_pkg::MAX_CODE_LENGTH);
      else
         n = acpg_pkg::CNT_W'(code_length);
   end

   assign req_full = (cnt_ff == 2'd2);
   assign push = req_push && !req_full;
   assign job_valid = (cnt_ff != 2'd0);
   assign take = job_take && job_valid;
   assign job = q_ff[0];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, take};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (take) q_ff[0] <= q_ff[1];
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && take))
            q_ff[0] <= '{block: {req_counter_high, req_counter_low}, count: n};
         else
            q_ff[1] <= '{block: {req_counter_high, req_counter_low}, count: n};
      end
   end
endmodule

FILE: rtl/acpg_cipher.sv
// Iterative AES-256 core: one round and one key schedule step per cycle.
// Depends on acpg_pkg.
module acpg_cipher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [255:0]         key,
   input  logic                 job_valid,
   output logic                 job_take,
   input  acpg_pkg::job_type    job,
   output logic                 ct_valid,
   input  logic                 ct_take,
   output acpg_pkg::cipher_type ct
);
   typedef enum logic [1:0] {IDLE, RUN, DONE} state_type;
   state_type state_ff;
   logic [acpg_pkg::ROUND_W-1:0] round_ff;
   logic [127:0] s_ff;
   logic [255:0] w_ff;
   logic [7:0] rcon_ff;
   logic [acpg_pkg::CNT_W-1:0] count_ff;
   logic [127:0] rk_next, s_next;
   logic odd, last, start;

   // During round r, w_ff holds round keys r-1 (upper) and r (lower); the round
   // uses the lower half, and the next key is computed from the whole window.
   assign odd = round_ff[0];
   assign last = (round_ff == acpg_pkg::ROUND_W'(acpg_pkg::AES_ROUNDS));
   assign rk_next = acpg_pkg::key_step(w_ff, !odd, rcon_ff);
   assign s_next = acpg_pkg::aes_round(s_ff, w_ff[127:0], last);
   assign start = job_valid && (state_ff == IDLE || (state_ff == DONE && ct_take));
   assign job_take = start;
   assign ct_valid = (state_ff == DONE);
   assign ct = '{text: s_ff, count: count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE: if (start) state_ff <= RUN;
            RUN: if (last) state_ff <= DONE;
            DONE: if (start) state_ff <= RUN;
                  else if (ct_take) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
      if (start) begin
         s_ff <= job.block ^ key[255:128];
         w_ff <= key;
         round_ff <= acpg_pkg::ROUND_W'(1);
         rcon_ff <= 8'h01;
         count_ff <= job.count;
      end else if (state_ff == RUN) begin
         s_ff <= s_next;
         w_ff <= {w_ff[127:0], rk_next};
         round_ff <= round_ff + acpg_pkg::ROUND_W'(1);
         if (!odd) rcon_ff <= acpg_pkg::xtime(rcon_ff);
      end
   end
endmodule

FILE: rtl/acpg_serializer.sv
// Back end: splits a ciphertext into base-64 digits and emits one character
// per cycle while not stalled, via an output register. Depends on acpg_pkg.
module acpg_serializer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 ct_valid,
   output logic                 ct_take,
   input  acpg_pkg::cipher_type ct,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [6:0]           rsp_char_code,
   output logic [3:0]           rsp_char_index,
   output logic                 rsp_last_char
);
   logic busy_ff;
   logic [127:0] bits_ff;
   logic [acpg_pkg::CNT_W-1:0] left_ff, pos_ff;
   logic out_v_ff;
   logic [6:0] code_ff;
   logic [3:0] idx_ff;
   logic last_ff;
   logic room, emit;

   assign room = !out_v_ff || rsp_pop;
   assign emit = busy_ff && room;
   assign ct_take = ct_valid && (!busy_ff || (emit && left_ff == acpg_pkg::CNT_W'(1)));
   assign rsp_empty = !out_v_ff;
   assign rsp_char_code = code_ff;
   assign rsp_char_index = idx_ff;
   assign rsp_last_char = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (room) out_v_ff <= emit;
         if (ct_take) busy_ff <= 1'b1;
         else if (emit && left_ff == acpg_pkg::CNT_W'(1)) busy_ff <= 1'b0;
      end
      if (emit) begin
         code_ff <= acpg_pkg::glyph(bits_ff[5:0]);
         idx_ff <= pos_ff[3:0];
         last_ff <= (left_ff == acpg_pkg::CNT_W'(1));
      end
      // Load a new ciphertext, or advance to the next digit.
      if (ct_take) begin
         bits_ff <= ct.text;
         left_ff <= ct.count;
         pos_ff <= '0;
      end else if (emit) begin
         bits_ff <= {6'd0, bits_ff[127:6]};
         left_ff <= left_ff - acpg_pkg::CNT_W'(1);
         pos_ff <= pos_ff + acpg_pkg::CNT_W'(1);
      end
   end
endmodule
